@@ src/rdd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdd_pkg
// Shared types and constants for the rotary detent debouncer.
// ---------------------------------------------------------------------------
package rdd_pkg;

    // number of encoder channels with state
    localparam int CHANNELS = 8;

    // field widths
    localparam int CH_W       = 3;
    localparam int DELTA_W    = 16;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;

    // state memory address width
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((CH_W + DELTA_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CH_W + 1 + 7) / 8) * 8;

    // reset value of the minimum emit interval
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd60;

    // single count codes of the raw delta
    localparam logic [DELTA_W-1:0] DELTA_PLUS_ONE  = 16'h0001;
    localparam logic [DELTA_W-1:0] DELTA_MINUS_ONE = 16'hFFFF;

    // per channel state entry
    typedef struct packed {
        logic              awaiting_pair;
        logic              half_positive;
        logic [TIME_W-1:0] last_emit_ms;
    } chan_state_t;

endpackage

@@ src/rdd_state_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdd_state_ram
// Per channel state memory: one synchronous write port and one read port
// with registered read data.
// ---------------------------------------------------------------------------
module rdd_state_ram (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [rdd_pkg::ADDR_W-1:0] rd_addr,
    output rdd_pkg::chan_state_t      rd_data,
    input  logic                      wr_en,
    input  logic [rdd_pkg::ADDR_W-1:0] wr_addr,
    input  rdd_pkg::chan_state_t      wr_data
);

    rdd_pkg::chan_state_t mem [rdd_pkg::CHANNELS];
    rdd_pkg::chan_state_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/rotary_detent_debouncer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotary_detent_debouncer
// Per channel detent filter: pairs single counts into detents and rate
// limits emitted detents per channel.
// ---------------------------------------------------------------------------
// channel   | direction | bits | contents
// s_*       | in        | 56   | poll: channel, count_delta, now_ms
// m_*       | out       | 8    | detent: out_channel, step_up
// cfg_*     | in        | 16   | min_emit_interval_ms write
//
// One poll per cycle while the output is not stalled; a poll's detent shows on
// m_tdata after the state memory read register, then the update and output register.
// State reads are forwarded from the previous write to cover back to back
// polls of the same channel.
// After reset all channel state reads as zero through per entry valid bits.
// A stalled output register holds the whole pipeline and drops s_tready.
// ---------------------------------------------------------------------------
module rotary_detent_debouncer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] channel, [18:3] count_delta, [50:19] now_ms, rest zero
    input  logic [rdd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] out_channel, [3] step_up, rest zero
    output logic [rdd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [rdd_pkg::INTERVAL_W-1:0]  cfg_wdata
);

    // input unpacking
    logic [rdd_pkg::CH_W-1:0]    in_channel;
    logic [rdd_pkg::DELTA_W-1:0] in_delta;
    logic [rdd_pkg::TIME_W-1:0]  in_now;

    assign in_channel = s_tdata[rdd_pkg::CH_W-1:0];
    assign in_delta   = s_tdata[rdd_pkg::CH_W +: rdd_pkg::DELTA_W];
    assign in_now     = s_tdata[rdd_pkg::CH_W + rdd_pkg::DELTA_W +: rdd_pkg::TIME_W];

    // registers
    logic [rdd_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           s1_valid_reg;
    logic [rdd_pkg::CH_W-1:0]       s1_channel_reg;
    logic [rdd_pkg::DELTA_W-1:0]    s1_delta_reg;
    logic [rdd_pkg::TIME_W-1:0]     s1_now_reg;
    logic [rdd_pkg::CHANNELS-1:0]   entry_valid_reg;
    logic                           rd_valid_reg;
    logic                           fwd_valid_reg;
    logic [rdd_pkg::ADDR_W-1:0]     fwd_addr_reg;
    rdd_pkg::chan_state_t           fwd_state_reg;
    logic                           out_valid_reg;
    logic [rdd_pkg::CH_W-1:0]       out_channel_reg;
    logic                           out_up_reg;

    // pipeline control
    logic                       advance;
    logic                       accept;
    logic [rdd_pkg::ADDR_W-1:0] rd_addr;
    logic [rdd_pkg::ADDR_W-1:0] s1_addr;
    rdd_pkg::chan_state_t       ram_rd_data;

    assign advance  = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && advance;
    assign s_tready = advance;
    assign rd_addr  = rdd_pkg::ADDR_W'(in_channel);
    assign s1_addr  = rdd_pkg::ADDR_W'(s1_channel_reg);

    // stage 1 update logic
    rdd_pkg::chan_state_t       cur_state;
    rdd_pkg::chan_state_t       state_next;
    logic                       in_range;
    logic                       active;
    logic                       up;
    logic                       single;
    logic                       detent;
    logic                       time_ok;
    logic                       emit;
    logic [rdd_pkg::TIME_W-1:0] elapsed;
    logic                       wr_en;

    always_comb
    begin
        // current state: forwarded write, stored entry, or reset value
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur_state = fwd_state_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_state = ram_rd_data;
        end
        else
        begin
            cur_state = '0;
        end

        in_range = 32'(s1_channel_reg) < 32'(rdd_pkg::CHANNELS);
        active   = s1_valid_reg && in_range && (s1_delta_reg != '0);
        up       = !s1_delta_reg[rdd_pkg::DELTA_W-1];
        single   = (s1_delta_reg == rdd_pkg::DELTA_PLUS_ONE)
                || (s1_delta_reg == rdd_pkg::DELTA_MINUS_ONE);
        elapsed  = s1_now_reg - cur_state.last_emit_ms;
        time_ok  = elapsed >= rdd_pkg::TIME_W'(interval_reg);

        state_next = cur_state;
        detent     = 1'b0;
        if (single)
        begin
            if (!cur_state.awaiting_pair)
            begin
                state_next.awaiting_pair = 1'b1;
                state_next.half_positive = up;
            end
            else if (cur_state.half_positive == up)
            begin
                state_next.awaiting_pair = 1'b0;
                detent                   = 1'b1;
            end
            else
            begin
                state_next.half_positive = up;
            end
        end
        else
        begin
            state_next.awaiting_pair = 1'b0;
            detent                   = 1'b1;
        end

        emit = active && detent && time_ok;
        if (detent && time_ok)
        begin
            state_next.last_emit_ms = s1_now_reg;
        end

        wr_en = active && advance;
    end

    // state memory
    rdd_state_ram u_state_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (state_next)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= rdd_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    // pipeline control state and entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= s_tvalid;
                fwd_valid_reg <= wr_en;
                out_valid_reg <= emit;
            end
            if (accept)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                entry_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg <= in_channel;
            s1_delta_reg   <= in_delta;
            s1_now_reg     <= in_now;
        end
        if (wr_en)
        begin
            fwd_addr_reg  <= s1_addr;
            fwd_state_reg <= state_next;
        end
        if (advance && emit)
        begin
            out_channel_reg <= s1_channel_reg;
            out_up_reg      <= up;
        end
    end

    // output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdd_pkg::M_TDATA_W'({out_up_reg, out_channel_reg});

endmodule

@@ src/rdd_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdd_checker
// Port level checks for the rotary detent debouncer, bound to the top level.
// ---------------------------------------------------------------------------
module rdd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rdd_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled output transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

    // a stalled output payload holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

    // input backpressure only comes from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

    // a new detent needs an input transaction that passed the stage 1 and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> ##1 !$rose(m_tvalid))
    else $error("detent without a matching poll");

    // pad bits of the output payload stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[rdd_pkg::M_TDATA_W-1:rdd_pkg::CH_W+1] == '0))
    else $error("m_tdata pad bits not zero");

endmodule

bind rotary_detent_debouncer rdd_checker u_rdd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/rotary_detent_debouncer_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotary_detent_debouncer_test
// Stream bench for the detent debouncer: a queue fed driver offers polls,
// a scoreboard predicts each detent per channel, and a monitor checks the
// detent stream in order while both ends idle and stall at random.
// ---------------------------------------------------------------------------
module rotary_detent_debouncer_test;

    // bench timing
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;

    // one poll, laid out as on s_tdata (channel in the low bits)
    typedef struct packed {
        logic [rdd_pkg::TIME_W-1:0]  now_ms;
        logic [rdd_pkg::DELTA_W-1:0] count_delta;
        logic [rdd_pkg::CH_W-1:0]    channel;
    } poll_t;

    // one detent
    typedef struct packed {
        logic [rdd_pkg::CH_W-1:0] channel;
        logic                     step_up;
    } detent_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // [2:0] channel, [18:3] count_delta, [50:19] now_ms, rest zero
    logic [rdd_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [2:0] out_channel, [3] step_up, rest zero
    logic [rdd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_we;
    logic [rdd_pkg::INTERVAL_W-1:0] cfg_wdata;

    // stimulus and scoreboard
    poll_t   poll_q[$];
    detent_t detent_q[$];

    // predicted block state
    logic [rdd_pkg::INTERVAL_W-1:0] emit_interval;
    logic                           pair_pending [rdd_pkg::CHANNELS];
    logic                           pair_up [rdd_pkg::CHANNELS];
    logic [rdd_pkg::TIME_W-1:0]     last_emit [rdd_pkg::CHANNELS];

    // generator state
    logic                           gen_up [rdd_pkg::CHANNELS];
    logic [rdd_pkg::TIME_W-1:0]     gen_now;

    // bench control
    logic quiet;
    logic hold_armed;
    logic hold_done;
    int   hold_count;
    int   stall_cycles;
    int   errors;

    rotary_detent_debouncer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #5 clk = ~clk;

    // pair single counts, rate limit detents, queue the emitted ones
    task automatic predict_detent(input logic [rdd_pkg::CH_W-1:0] ch,
                                  input logic [rdd_pkg::DELTA_W-1:0] delta,
                                  input logic [rdd_pkg::TIME_W-1:0] now);
        logic                       up;
        logic                       detent;
        logic [rdd_pkg::TIME_W-1:0] elapsed;
        up     = ~delta[rdd_pkg::DELTA_W-1];
        detent = 1'b0;
        if (delta == '0 || ch >= rdd_pkg::CHANNELS)
            return;
        if (delta == rdd_pkg::DELTA_PLUS_ONE || delta == rdd_pkg::DELTA_MINUS_ONE)
        begin
            if (!pair_pending[ch])
            begin
                pair_pending[ch] = 1'b1;
                pair_up[ch]      = up;
            end
            else if (pair_up[ch] == up)
            begin
                pair_pending[ch] = 1'b0;
                detent           = 1'b1;
            end
            else
            begin
                pair_up[ch] = up;
            end
        end
        else
        begin
            pair_pending[ch] = 1'b0;
            detent           = 1'b1;
        end
        if (detent)
        begin
            // wrapping elapsed time since the last emitted detent
            elapsed = now - last_emit[ch];
            if (elapsed >= rdd_pkg::TIME_W'(emit_interval))
            begin
                last_emit[ch] = now;
                detent_q.push_back('{channel: ch, step_up: up});
            end
        end
    endtask

    task automatic queue_poll(input int ch, input logic [rdd_pkg::DELTA_W-1:0] delta,
                              input logic [rdd_pkg::TIME_W-1:0] now);
        poll_q.push_back('{now_ms: now, count_delta: delta,
                           channel: rdd_pkg::CH_W'(ch)});
    endtask

    // random polls: single counts, full detents, noise; or full detents only
    task automatic run_phase(input int count, input bit full_only);
        int                          ch;
        int                          pick;
        int                          step_max;
        logic [rdd_pkg::DELTA_W-1:0] mag;
        logic [rdd_pkg::DELTA_W-1:0] delta;
        step_max = int'(emit_interval) / 4 + 2;
        for (int n = 0; n < count; n++)
        begin
            ch   = $urandom_range(0, rdd_pkg::CHANNELS - 1);
            pick = $urandom_range(0, 99);
            if (full_only || (pick >= 50 && pick < 70))
            begin
                mag   = rdd_pkg::DELTA_W'($urandom_range(2, full_only ? 300 : 8));
                delta = $urandom_range(0, 1) ? mag : -mag;
            end
            else if (pick < 50)
            begin
                if ($urandom_range(0, 99) < 20)
                    gen_up[ch] = ~gen_up[ch];
                delta = gen_up[ch] ? rdd_pkg::DELTA_PLUS_ONE : rdd_pkg::DELTA_MINUS_ONE;
            end
            else if (pick < 82)
            begin
                delta = rdd_pkg::DELTA_W'($urandom());
            end
            else if (pick < 90)
            begin
                delta = '0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       delta = 16'h7FFF;
                    1:       delta = 16'h8000;
                    2:       delta = 16'h0002;
                    default: delta = 16'hFFFE;
                endcase
            end
            // time mostly creeps forward, sometimes jumps anywhere
            if ($urandom_range(0, 99) < 4)
                gen_now = $urandom();
            else
                gen_now = gen_now + rdd_pkg::TIME_W'($urandom_range(0, step_max));
            queue_poll(ch, delta, gen_now);
        end
    endtask

    // wait until every poll is taken and every detent has come out
    task automatic settle();
        while (poll_q.size() != 0 || detent_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_interval(input logic [rdd_pkg::INTERVAL_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        emit_interval  = value;
        @(negedge clk);
    endtask

    // poll driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_detent(s_tdata[rdd_pkg::CH_W-1:0],
                               s_tdata[rdd_pkg::CH_W +: rdd_pkg::DELTA_W],
                               s_tdata[rdd_pkg::CH_W+rdd_pkg::DELTA_W +: rdd_pkg::TIME_W]);
                void'(poll_q.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (poll_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 25))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rdd_pkg::S_TDATA_W'(poll_q[0]);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // detent monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : detent_monitor
        detent_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (detent_q.size() == 0)
                begin
                    $error("unexpected detent transaction: out_channel %0d step_up %0d",
                           m_tdata[rdd_pkg::CH_W-1:0], m_tdata[rdd_pkg::CH_W]);
                    errors++;
                end
                else
                begin
                    want = detent_q.pop_front();
                    if (m_tdata[rdd_pkg::CH_W-1:0] !== want.channel)
                    begin
                        $error("out_channel: expected %0d, actual %0d",
                               want.channel, m_tdata[rdd_pkg::CH_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[rdd_pkg::CH_W] !== want.step_up)
                    begin
                        $error("step_up: expected %0d, actual %0d",
                               want.step_up, m_tdata[rdd_pkg::CH_W]);
                        errors++;
                    end
                end
            end
            // long hold-off once, else random stalls
            if (hold_armed && !hold_done)
            begin
                m_tready   <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else
            begin
                m_tready <= quiet || $urandom_range(0, 99) >= 25;
            end
        end
    end

    // watchdog on cycles with work pending but no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (poll_q.size() == 0 && detent_q.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("rotary_detent_debouncer_test: errors");
            $finish;
        end
    end

    // reset, directed polls, then random phases over several intervals
    initial
    begin
        errors        = 0;
        quiet         = 1'b0;
        hold_armed    = 1'b0;
        stall_cycles  = 0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        emit_interval = rdd_pkg::INTERVAL_RESET;
        gen_now       = '0;
        for (int i = 0; i < rdd_pkg::CHANNELS; i++)
        begin
            pair_pending[i] = 1'b0;
            pair_up[i]      = 1'b0;
            last_emit[i]    = '0;
            gen_up[i]       = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pair completes, then opposite count restarts and a late pair drops
        queue_poll(0, rdd_pkg::DELTA_PLUS_ONE, 100);
        queue_poll(0, rdd_pkg::DELTA_PLUS_ONE, 100);
        queue_poll(0, rdd_pkg::DELTA_MINUS_ONE, 105);
        queue_poll(0, rdd_pkg::DELTA_PLUS_ONE, 106);
        queue_poll(0, rdd_pkg::DELTA_PLUS_ONE, 110);
        queue_poll(0, rdd_pkg::DELTA_PLUS_ONE, 111);
        queue_poll(0, rdd_pkg::DELTA_MINUS_ONE, 112);
        // zero delta, extreme deltas, too soon and exactly on the interval
        queue_poll(1, 16'h0000, 500);
        queue_poll(1, 16'h7FFF, 200);
        queue_poll(1, 16'h8000, 230);
        queue_poll(1, 16'h8000, 260);
        // full detent clears a pending half
        queue_poll(2, rdd_pkg::DELTA_PLUS_ONE, 300);
        queue_poll(2, 16'hFFFE, 300);
        queue_poll(2, rdd_pkg::DELTA_PLUS_ONE, 400);
        queue_poll(2, rdd_pkg::DELTA_PLUS_ONE, 459);
        // timestamps across the wrap
        queue_poll(7, rdd_pkg::DELTA_MINUS_ONE, 32'hFFFF_FFFF);
        queue_poll(7, rdd_pkg::DELTA_MINUS_ONE, 32'hFFFF_FFFF);
        queue_poll(7, 16'h0002, 32'h0000_003A);
        queue_poll(7, 16'h0002, 32'h0000_003B);
        // first detent at time zero is too soon after reset
        queue_poll(3, 16'h8000, 0);
        queue_poll(3, 16'h7FFF, 59);
        queue_poll(3, 16'h0002, 60);
        queue_poll(4, 16'hFFFE, 1000);
        queue_poll(5, 16'h0003, 1000);
        queue_poll(6, 16'h8001, 1000);
        settle();

        // no idling at all, every detent passes
        quiet = 1'b1;
        write_interval(16'd0);
        run_phase(250, 1'b0);
        settle();
        quiet = 1'b0;

        write_interval(16'hFFFF);
        run_phase(250, 1'b0);
        settle();

        write_interval(16'd1);
        run_phase(250, 1'b0);
        settle();

        // random interval with time close to the wrap
        write_interval(rdd_pkg::INTERVAL_W'($urandom_range(0, 65535)));
        gen_now = 32'hFFFF_0000;
        run_phase(250, 1'b0);
        settle();

        // receiver holds off while full detents keep coming
        write_interval(16'd0);
        hold_armed = 1'b1;
        run_phase(200, 1'b1);
        settle();

        write_interval(rdd_pkg::INTERVAL_RESET);
        run_phase(300, 1'b0);
        settle();

        write_interval(rdd_pkg::INTERVAL_W'($urandom_range(0, 65535)));
        run_phase(300, 1'b0);
        settle();

        if (detent_q.size() != 0)
        begin
            $error("detents still expected at the end: %0d", detent_q.size());
            errors++;
        end
        if (errors == 0)
            $display("rotary_detent_debouncer_test: clean");
        else
            $display("rotary_detent_debouncer_test: errors");
        $finish;
    end

endmodule
